// ===== sv/sfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the start-of-frame / length / XOR frame
// parser: event codes, the start byte and the result record.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned MAX_PAYLOAD_DEFAULT = 128;

  localparam logic [7:0] SOF_BYTE = 8'hFE;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_BYTE = 3'd1,
    EV_GOOD = 3'd2,
    EV_BAD  = 3'd3,
    EV_LONG = 3'd4
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic [15:0] function_code;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic [6:0]  payload_index;
  } result_t;

endpackage : sfp_pkg
`default_nettype wire

// ===== sv/sof_length_xor_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sof_length_xor_frame_parser
// Frame parser for a byte stream: start byte 0xFE, 16-bit function code,
// 16-bit payload length, payload bytes and an XOR checksum byte.
// ----------------------------------------------------------------------------
// The rx channel takes one received byte per transfer. The res channel gives
// exactly one result per byte: an event code, the current function code and
// payload length, and for payload bytes the byte and its position.
// A taken byte's result is registered and shown on res from the next cycle
// on. Throughput is one byte per cycle while the receiver does not stall,
// set by the combinational parse logic in front of the result register.
// A new byte is taken while the held result is being transferred, so a
// receiver that takes every result sees no gaps. When the receiver stalls,
// rx_ready drops until the held result is transferred; nothing is lost.
// Reset returns the parser to hunting for the start byte, clears the
// function code, length, byte count and checksum, and empties the result
// register.
// ----------------------------------------------------------------------------
module sof_length_xor_frame_parser
  import sfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [2:0]       event_res,
  output logic [15:0]      function_code,
  output logic [15:0]      payload_length,
  output logic [7:0]       payload_byte,
  output logic [6:0]       payload_index
);

  logic    take;
  result_t core_result;
  result_t held;

  assign take = rx_valid && rx_ready;

  sfp_parser_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .rx_byte(rx_byte),
    .result (core_result)
  );

  sfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .load_data (core_result),
    .space     (rx_ready),
    .hold_valid(res_valid),
    .hold_ready(res_ready),
    .hold_data (held)
  );

  assign event_res      = held.event_res;
  assign function_code  = held.function_code;
  assign payload_length = held.payload_length;
  assign payload_byte   = held.payload_byte;
  assign payload_index  = held.payload_index;

`ifndef NO_ASSERTIONS
  a_reset_empties: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result register not empty after reset");

  a_stall_blocks_rx: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !rx_ready)
    else $error("byte taken while a result is stalled");

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready |=> res_valid)
    else $error("transfer on rx gave no result");

  a_payload_fields_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res != EV_BYTE |-> payload_byte == 8'd0 && payload_index == 7'd0)
    else $error("payload fields set on a non-payload event");
`endif

endmodule : sof_length_xor_frame_parser
`default_nettype wire

// ===== sv/sfp_parser_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_parser_core
// Parse state machine, header registers, payload count and running XOR.
// The result of a byte is formed combinationally from the current state.
// ----------------------------------------------------------------------------
module sfp_parser_core
  import sfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  output result_t         result
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [6:0] {
    PH_WAIT    = 7'b0000001,
    PH_FUNC_HI = 7'b0000010,
    PH_FUNC_LO = 7'b0000100,
    PH_LEN_HI  = 7'b0001000,
    PH_LEN_LO  = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_t;

  phase_t           phase;
  phase_t           phase_next;
  logic [15:0]      function_reg;
  logic [15:0]      function_reg_next;
  logic [15:0]      length_reg;
  logic [15:0]      length_reg_next;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       running_xor;
  logic [7:0]       running_xor_next;

  logic [CNT_W-1:0] count_inc;
  logic [15:0]      count_wide;
  event_t           ev;
  logic [7:0]       pbyte;
  logic [6:0]       pidx;

  assign count_inc  = byte_count + CNT_W'(1);
  assign count_wide = 16'(byte_count);

  always_comb begin
    phase_next        = phase;
    function_reg_next = function_reg;
    length_reg_next   = length_reg;
    byte_count_next   = byte_count;
    running_xor_next  = running_xor;
    ev                = EV_NONE;
    pbyte             = 8'd0;
    pidx              = 7'd0;
    case (phase)
      PH_WAIT: begin
        if (rx_byte == SOF_BYTE) begin
          running_xor_next = SOF_BYTE;
          byte_count_next  = '0;
          phase_next       = PH_FUNC_HI;
        end
      end
      PH_FUNC_HI: begin
        function_reg_next = {rx_byte, 8'd0};
        running_xor_next  = running_xor ^ rx_byte;
        phase_next        = PH_FUNC_LO;
      end
      PH_FUNC_LO: begin
        function_reg_next = {function_reg[15:8], rx_byte};
        running_xor_next  = running_xor ^ rx_byte;
        phase_next        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_reg_next  = {rx_byte, 8'd0};
        running_xor_next = running_xor ^ rx_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_reg_next  = {length_reg[15:8], rx_byte};
        running_xor_next = running_xor ^ rx_byte;
        byte_count_next  = '0;
        if ({length_reg[15:8], rx_byte} == 16'd0) begin
          phase_next = PH_CHECK;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (byte_count < CNT_W'(MAX_PAYLOAD)) begin
          ev               = EV_BYTE;
          pbyte            = rx_byte;
          pidx             = count_wide[6:0];
          running_xor_next = running_xor ^ rx_byte;
          byte_count_next  = count_inc;
          if (16'(count_inc) >= length_reg) begin
            phase_next = PH_CHECK;
          end
        end else begin
          ev         = EV_LONG;
          phase_next = PH_WAIT;
        end
      end
      PH_CHECK: begin
        ev         = (running_xor == rx_byte) ? EV_GOOD : EV_BAD;
        phase_next = PH_WAIT;
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      function_reg <= 16'd0;
      length_reg   <= 16'd0;
      byte_count   <= '0;
      running_xor  <= 8'd0;
    end else if (take) begin
      phase        <= phase_next;
      function_reg <= function_reg_next;
      length_reg   <= length_reg_next;
      byte_count   <= byte_count_next;
      running_xor  <= running_xor_next;
    end
  end

  assign result.event_res      = ev;
  assign result.function_code  = function_reg_next;
  assign result.payload_length = length_reg_next;
  assign result.payload_byte   = pbyte;
  assign result.payload_index  = pidx;

endmodule : sfp_parser_core
`default_nettype wire

// ===== sv/sfp_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_out_reg
// Result register between the parser and the receiving side. It can take a
// new result in the same cycle that the held one is transferred.
// ----------------------------------------------------------------------------
module sfp_out_reg
  import sfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         space,
  output logic         hold_valid,
  input  wire logic    hold_ready,
  output result_t      hold_data
);

  logic hold_valid_next;

  assign space = !hold_valid || hold_ready;

  always_comb begin
    hold_valid_next = hold_valid;
    if (load) begin
      hold_valid_next = 1'b1;
    end else if (hold_ready) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_data <= load_data;
    end
  end

endmodule : sfp_out_reg
`default_nettype wire

// ===== tb/sof_length_xor_frame_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_length_xor_frame_parser_checker
// Watches both channels of the frame parser. Every received byte that is
// transferred is run through a local copy of the parse state machine, and
// the result it gives is queued. Every result transfer is compared field by
// field with the oldest queued result. The number of mismatches and the
// number of results still outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module sof_length_xor_frame_parser_checker
  import sfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  input  wire logic        rx_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        res_valid,
  input  wire logic        res_ready,
  input  wire logic [2:0]  event_res,
  input  wire logic [15:0] function_code,
  input  wire logic [15:0] payload_length,
  input  wire logic [7:0]  payload_byte,
  input  wire logic [6:0]  payload_index,
  output int               fail_count,
  output int               pending_count
);

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_FUNC_HI = 3'd1,
    PH_FUNC_LO = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  phase_t      phase;
  logic [15:0] func_code;
  logic [15:0] frame_len;
  logic [7:0]  taken_count;
  logic [7:0]  frame_xor;

  result_t pending_results[$];

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  task automatic clear_parser();
    phase = PH_WAIT;
    func_code = '0;
    frame_len = '0;
    taken_count = '0;
    frame_xor = '0;
  endtask

  function automatic result_t parse_byte(logic [7:0] b);
    result_t r;
    r = '0;
    r.event_res = EV_NONE;
    case (phase)
      PH_WAIT: begin
        if (b == SOF_BYTE) begin
          frame_xor = SOF_BYTE;
          taken_count = '0;
          phase = PH_FUNC_HI;
        end
      end
      PH_FUNC_HI: begin
        func_code = {b, 8'h00};
        frame_xor ^= b;
        phase = PH_FUNC_LO;
      end
      PH_FUNC_LO: begin
        func_code[7:0] = b;
        frame_xor ^= b;
        phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len = {b, 8'h00};
        frame_xor ^= b;
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len[7:0] = b;
        frame_xor ^= b;
        taken_count = '0;
        phase = (frame_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (int'(taken_count) < int'(MAX_PAYLOAD)) begin
          r.event_res = EV_BYTE;
          r.payload_byte = b;
          r.payload_index = taken_count[6:0];
          frame_xor ^= b;
          taken_count = taken_count + 8'd1;
          if ({8'd0, taken_count} >= frame_len) begin
            phase = PH_CHECK;
          end
        end else begin
          r.event_res = EV_LONG;
          phase = PH_WAIT;
        end
      end
      PH_CHECK: begin
        r.event_res = (frame_xor == b) ? EV_GOOD : EV_BAD;
        phase = PH_WAIT;
      end
      default: begin
        phase = PH_WAIT;
      end
    endcase
    r.function_code = func_code;
    r.payload_length = frame_len;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_parser();
      pending_results.delete();
      pending_count <= 0;
    end else begin
      if (rx_valid && rx_ready) begin
        pending_results.push_back(parse_byte(rx_byte));
      end
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with none outstanding", event_res, 0);
        end else begin
          want = pending_results.pop_front();
          if (event_res !== 3'(want.event_res)) begin
            report_mismatch("event_res", event_res, want.event_res);
          end
          if (function_code !== want.function_code) begin
            report_mismatch("function_code", function_code, want.function_code);
          end
          if (payload_length !== want.payload_length) begin
            report_mismatch("payload_length", payload_length, want.payload_length);
          end
          if (payload_byte !== want.payload_byte) begin
            report_mismatch("payload_byte", payload_byte, want.payload_byte);
          end
          if (payload_index !== want.payload_index) begin
            report_mismatch("payload_index", payload_index, want.payload_index);
          end
        end
      end
      pending_count <= pending_results.size();
    end
  end

endmodule : sof_length_xor_frame_parser_checker

// ===== tb/sof_length_xor_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_length_xor_frame_parser_tb
// Drives the frame parser with a short directed byte sequence and then with
// random frames mixed with noise, truncated and corrupted frames, across
// phases of sender idling and receiver stalling. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module sof_length_xor_frame_parser_tb;
  import sfp_pkg::*;

  localparam int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT;
  localparam int ITEM_BUDGET = 1200;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [2:0]  event_res;
  logic [15:0] function_code;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;
  logic [6:0]  payload_index;

  int fail_count;
  int pending_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic hold_trig = 1'b0;
  logic hold_seen = 1'b0;

  always #1 clk = ~clk;

  sof_length_xor_frame_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_ready(rx_ready),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .event_res(event_res),
    .function_code(function_code),
    .payload_length(payload_length),
    .payload_byte(payload_byte),
    .payload_index(payload_index)
  );

  sof_length_xor_frame_parser_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_ready(rx_ready),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .event_res(event_res),
    .function_code(function_code),
    .payload_length(payload_length),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .fail_count(fail_count),
    .pending_count(pending_count)
  );

  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sof_length_xor_frame_parser_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Checksum kind: 0 good, 1 corrupted, 2 left out.
  task automatic send_frame(logic [15:0] func, logic [15:0] len, int n_payload, int sum_kind);
    logic [7:0] sum;
    logic [7:0] b;
    sum = SOF_BYTE ^ func[15:8] ^ func[7:0] ^ len[15:8] ^ len[7:0];
    send_byte(SOF_BYTE);
    send_byte(func[15:8]);
    send_byte(func[7:0]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < n_payload; i++) begin
      b = 8'($urandom);
      sum ^= b;
      send_byte(b);
    end
    if (sum_kind == 0) begin
      send_byte(sum);
    end else if (sum_kind == 1) begin
      send_byte(sum ^ (8'h01 << $urandom_range(7)));
    end
  endtask

  task automatic send_random_frame(int k);
    logic [15:0] func;
    logic [15:0] len;
    int pick;
    int kind;
    func = 16'($urandom);
    pick = $urandom_range(99);
    kind = $urandom_range(99);
    if (k % 50 == 20) begin
      send_frame(func, 16'(MAX_PAYLOAD), MAX_PAYLOAD, 0);
    end else if (k % 50 == 45) begin
      len = (pick < 50) ? 16'hFFFF : 16'($urandom_range(65535, MAX_PAYLOAD + 1));
      send_frame(func, len, MAX_PAYLOAD + 1, 2);
    end else begin
      if (pick < 12) begin
        len = 16'd0;
      end else if (pick < 85) begin
        len = 16'($urandom_range(8, 1));
      end else begin
        len = 16'($urandom_range(24, 9));
      end
      if (kind < 78) begin
        send_frame(func, len, int'(len), 0);
      end else if (kind < 92) begin
        send_frame(func, len, int'(len), 1);
      end else begin
        send_frame(func, len, (len == 0) ? 0 : $urandom_range(len - 1), 2);
      end
    end
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_frame(16'h0000, 16'h0000, 0, 0);
    send_byte(8'h01);
    send_frame(16'hFFFF, 16'h0001, 1, 1);
    send_frame(16'hA55A, 16'h0002, 2, 0);

    k = 0;
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          hold_trig <= ~hold_trig;
        end
        1: begin
          send_idle_pct = 62;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 62;
        end
        default: begin
          send_idle_pct = 6;
          recv_stall_pct <= 6;
        end
      endcase
      while (bytes_sent < ITEM_BUDGET * (seg + 1) / 4) begin
        send_random_frame(k);
        k++;
      end
    end

    rx_valid <= 1'b0;
    recv_stall_pct <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("sof_length_xor_frame_parser_tb: done, clean");
    end else begin
      $display("sof_length_xor_frame_parser_tb: done, errors");
    end
    $finish;
  end

endmodule : sof_length_xor_frame_parser_tb

// ===== sim.f =====
sv/sfp_pkg.sv
sv/sfp_parser_core.sv
sv/sfp_out_reg.sv
sv/sof_length_xor_frame_parser.sv
tb/sof_length_xor_frame_parser_checker.sv
tb/sof_length_xor_frame_parser_tb.sv
